FILE: rtl/aes_sbox_pkg.sv
// Package with GF(2^8) arithmetic and affine transforms for the AES S-box.
`timescale 1ns / 1ps
`default_nettype none

package aes_sbox_pkg;

    // Reduction term of x^8+x^4+x^3+x+1 once x^8 is dropped.
    localparam logic [7:0] GF_REDUCE = 8'h1B;
    // Constant added by the forward affine transform.
    localparam logic [7:0] FWD_CONST = 8'h63;
    // Constant added by the inverse affine transform.
    localparam logic [7:0] INV_CONST = 8'h05;

    // Shift-and-add multiply in GF(2^8), reducing after each shift.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = '0;
        x   = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? GF_REDUCE : 8'h00);
        end
        return acc;
    endfunction

    // Squaring is linear over GF(2), so this folds down to a few XOR gates.
    function automatic logic [7:0] gf_sq(input logic [7:0] a);
        return gf_mul(a, a);
    endfunction

    // Forward affine: b ^ rotl1 ^ rotl2 ^ rotl3 ^ rotl4 ^ 0x63.
    function automatic logic [7:0] affine_fwd(input logic [7:0] b);
        return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
               ^ {b[3:0], b[7:4]} ^ FWD_CONST;
    endfunction

    // Inverse affine: rotl1 ^ rotl3 ^ rotl6 ^ 0x05.
    function automatic logic [7:0] affine_inv(input logic [7:0] b);
        return {b[6:0], b[7]} ^ {b[4:0], b[7:5]} ^ {b[1:0], b[7:2]} ^ INV_CONST;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/aes_sbox_forward_inverse.sv
// AES forward and inverse S-box as a four-stage pipeline.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one byte per clock cycle, every cycle, and busy stays low.
// Each item passes stages 1, 2 and 3 and the output register before its result
// shows on out_byte, with done high for a single cycle; the receiver cannot
// stall the block. The GF(2^8) inversion is computed as a^254 over three stages
// with one multiplier in the first and last stage and two side by side in the
// second, followed by the output register.
// The direction in inverse_mode is sampled when an item enters and travels with
// it; a cfg_we/cfg_wdata write is registered and applies to later items.
module aes_sbox_forward_inverse
    import aes_sbox_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [7:0] in_byte,
    output logic            done,
    output logic [7:0]      out_byte
);

    // Direction register.
    logic inverse_mode_reg;
    logic inverse_mode_next;

    // Stage 1: a, a^2, a^3.
    logic       s1_valid_reg;
    logic       s1_mode_reg;
    logic [7:0] s1_a2_reg;
    logic [7:0] s1_a3_reg;
    logic       s1_valid_next;
    logic [7:0] s1_a_in;
    logic [7:0] s1_a2_next;
    logic [7:0] s1_a3_next;

    // Stage 2: a^14, a^15.
    logic       s2_valid_reg;
    logic       s2_mode_reg;
    logic [7:0] s2_a14_reg;
    logic [7:0] s2_a15_reg;
    logic [7:0] s2_a12;
    logic [7:0] s2_a14_next;
    logic [7:0] s2_a15_next;

    // Stage 3: a^254, the field inverse.
    logic       s3_valid_reg;
    logic       s3_mode_reg;
    logic [7:0] s3_inv_reg;
    logic [7:0] s3_a240;
    logic [7:0] s3_inv_next;

    // Output stage.
    logic       done_reg;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;

    // The pipeline moves every cycle, so an item is always welcome.
    assign busy = 1'b0;

    // Configuration write.
    assign inverse_mode_next = cfg_we ? cfg_wdata : inverse_mode_reg;

    // Stage 1 logic: inverse affine on entry in inverse mode, then a^2 and a^3.
    assign s1_valid_next = start & ~busy;
    assign s1_a_in       = inverse_mode_reg ? affine_inv(in_byte) : in_byte;
    assign s1_a2_next    = gf_sq(s1_a_in);
    assign s1_a3_next    = gf_mul(s1_a2_next, s1_a_in);

    // Stage 2 logic: a^12 by two squarings, then a^15 and a^14.
    assign s2_a12      = gf_sq(gf_sq(s1_a3_reg));
    assign s2_a15_next = gf_mul(s2_a12, s1_a3_reg);
    assign s2_a14_next = gf_mul(s2_a12, s1_a2_reg);

    // Stage 3 logic: a^240 by four squarings, then a^254.
    assign s3_a240     = gf_sq(gf_sq(gf_sq(gf_sq(s2_a15_reg))));
    assign s3_inv_next = gf_mul(s3_a240, s2_a14_reg);

    // Output logic: forward affine after inversion in forward mode.
    assign out_byte_next = s3_mode_reg ? s3_inv_reg : affine_fwd(s3_inv_reg);

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inverse_mode_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            inverse_mode_reg <= inverse_mode_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            done_reg         <= s3_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_mode_reg  <= inverse_mode_reg;
        s1_a2_reg    <= s1_a2_next;
        s1_a3_reg    <= s1_a3_next;
        s2_mode_reg  <= s1_mode_reg;
        s2_a14_reg   <= s2_a14_next;
        s2_a15_reg   <= s2_a15_next;
        s3_mode_reg  <= s2_mode_reg;
        s3_inv_reg   <= s3_inv_next;
        out_byte_reg <= out_byte_next;
    end

    assign done     = done_reg;
    assign out_byte = out_byte_reg;

    // An item taken in one stage shows up in the next stage in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> s2_valid_reg)
        else $error("stage 1 item did not reach stage 2");

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |=> s3_valid_reg)
        else $error("stage 2 item did not reach stage 3");

    // A result strobe is only ever produced by an item leaving stage 3.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s3_valid_reg))
        else $error("result strobe without an item in stage 3");

    // a^15 and a^14 are both zero exactly when the byte being inverted is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> ((s2_a15_reg == 8'h00) == (s2_a14_reg == 8'h00)))
        else $error("zero handling of the inversion chain is inconsistent");

endmodule

`default_nettype wire
